/* rtl/planar_xyc_inverse_kinematics_top_macros.svh */
// assertion macros for the planar xyc inverse kinematics block
`ifndef PLANAR_XYC_INVERSE_KINEMATICS_TOP_MACROS_SVH
`define PLANAR_XYC_INVERSE_KINEMATICS_TOP_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define PXYC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define PXYC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/pxyc_pkg.sv */
// shared types, constants and elaboration-time tables of the xyc kinematics block
package pxyc_pkg;

  // cordic length and field widths
  localparam int CORDIC_STAGES = 16;
  localparam int SHIFT_W       = 5;
  localparam int POS_W         = 32;
  localparam int ANG_W         = 26;
  localparam int JC_W          = 27;
  localparam int ARM_W         = 30;
  localparam int ROT_W         = 34;
  localparam int RED_W         = 25;
  localparam int QUO_W         = 19;
  localparam int FRAC_W        = 13;
  localparam int REM_W         = 6;
  localparam int PHASE_W       = 32;
  localparam int PADDR_W       = 5;
  localparam int PDATA_W       = 32;

  // angle constants
  localparam int     FULL_TURN       = 23592960;
  localparam int     CORDIC_GAIN_Q30 = 652032874;
  localparam longint TWO_PI_Q30      = 64'sd6746518852;

  // reciprocal of 45 for the reduced angle, exact for values below 2^25
  localparam int RECIP45     = 47721859;
  localparam int RECIP_SHIFT = 31;
  localparam int FRAC_CNT    = 45;

  // register map
  typedef enum logic [2:0] {
    REG_ARM_LENGTH    = 3'd0,
    REG_TOOL_OFFSET_X = 3'd1,
    REG_TOOL_OFFSET_Y = 3'd2,
    REG_TOOL_ANGLE    = 3'd3,
    REG_Y_LIMIT       = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic        [ARM_W-1:0] arm_length;
    logic signed [POS_W-1:0] tool_offset_x;
    logic signed [POS_W-1:0] tool_offset_y;
    logic signed [ANG_W-1:0] tool_angle;
    logic signed [POS_W-1:0] y_limit;
  } cfg_t;

  // rotation vector and phase handed from cell to cell
  typedef struct packed {
    logic signed [ROT_W-1:0] x;
    logic signed [ROT_W-1:0] y;
    logic signed [ROT_W-1:0] z;
  } rot_t;

  // item fields that travel alongside the cordic
  typedef struct packed {
    logic signed [POS_W-1:0] tcp_x;
    logic signed [POS_W-1:0] tcp_y;
    logic signed [JC_W-1:0]  joint_c;
    logic                    neg;
  } side_t;

  // shift and subtract quotient, only used while building constant tables
  function automatic longint unsigned udiv_shift(input longint unsigned num,
                                                 input longint unsigned den);
    longint unsigned quo;
    longint unsigned acc;
    int              b;
    quo = 0;
    acc = 0;
    for (b = 63; b >= 0; b--) begin
      acc = {acc[62:0], num[b]};
      if (acc >= den) begin
        acc    = acc - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // atan(2^-i) in 2^-32 turn, from the exact series in q62 radians
  function automatic longint atan_turn(input int unsigned i);
    longint          sum;
    longint          term;
    longint unsigned p;
    int              k;
    sum = 0;
    if (i == 0) begin
      return 64'sd536870912;
    end
    for (k = 0; k < 64; k++) begin
      p = longint'(i) * longint'(2 * k + 1);
      if (p <= 62) begin
        term = longint'(udiv_shift(64'd1 << (62 - p), 64'(2 * k + 1)));
        if (k % 2 == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
    end
    return (sum + TWO_PI_Q30 / 2) / TWO_PI_Q30;
  endfunction

  // rounded phase fraction for a remainder of the divide by 45
  function automatic int frac_of(input int b);
    return (b * 16384 + 45) / 90;
  endfunction

endpackage

/* rtl/pxyc_cfg_regs.sv */
// apb register bank holding arm length, tool offsets, tool angle and y limit
module pxyc_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pxyc_pkg::PADDR_W-1:0]  paddr,
  input  logic [pxyc_pkg::PDATA_W-1:0]  pwdata,
  output logic [pxyc_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output pxyc_pkg::cfg_t                cfg
);
  import pxyc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign cfg    = cfg_r;

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (paddr[PADDR_W-1:2])
        REG_ARM_LENGTH:    cfg_nxt.arm_length    = pwdata[ARM_W-1:0];
        REG_TOOL_OFFSET_X: cfg_nxt.tool_offset_x = pwdata;
        REG_TOOL_OFFSET_Y: cfg_nxt.tool_offset_y = pwdata;
        REG_TOOL_ANGLE:    cfg_nxt.tool_angle    = pwdata[ANG_W-1:0];
        REG_Y_LIMIT:       cfg_nxt.y_limit       = pwdata;
        default:           cfg_nxt               = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.arm_length    <= ARM_W'(665600);
      cfg_r.tool_offset_x <= '0;
      cfg_r.tool_offset_y <= '0;
      cfg_r.tool_angle    <= '0;
      cfg_r.y_limit       <= POS_W'(716800);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // read mux, signed registers sign extended
  always_comb begin
    case (paddr[PADDR_W-1:2])
      REG_ARM_LENGTH:    prdata = {{(PDATA_W-ARM_W){1'b0}}, cfg_r.arm_length};
      REG_TOOL_OFFSET_X: prdata = cfg_r.tool_offset_x;
      REG_TOOL_OFFSET_Y: prdata = cfg_r.tool_offset_y;
      REG_TOOL_ANGLE:    prdata = {{(PDATA_W-ANG_W){cfg_r.tool_angle[ANG_W-1]}},
                                   cfg_r.tool_angle};
      REG_Y_LIMIT:       prdata = cfg_r.y_limit;
      default:           prdata = '0;
    endcase
  end

endmodule

/* rtl/pxyc_angle_reduce.sv */
// angle difference, modulo 360 degrees and conversion to a cordic phase
`include "planar_xyc_inverse_kinematics_top_macros.svh"

module pxyc_angle_reduce (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic signed [pxyc_pkg::POS_W-1:0]   in_tcp_x,
  input  logic signed [pxyc_pkg::POS_W-1:0]   in_tcp_y,
  input  logic signed [pxyc_pkg::ANG_W-1:0]   in_tcp_angle,
  input  logic signed [pxyc_pkg::ANG_W-1:0]   tool_angle,
  output logic                                out_valid,
  output pxyc_pkg::rot_t                      out_rot,
  output pxyc_pkg::side_t                     out_side
);
  import pxyc_pkg::*;

  localparam logic signed [27:0] FT1 = 28'(FULL_TURN);
  localparam logic signed [27:0] FT2 = 28'(2 * FULL_TURN);
  localparam logic signed [27:0] FT3 = 28'(3 * FULL_TURN);
  localparam logic [25:0]        RECIP_C = 26'(RECIP45);

  // stage 1: angle difference
  logic                    s1_valid_r;
  logic signed [JC_W-1:0]  s1_d_r;
  logic signed [POS_W-1:0] s1_tx_r;
  logic signed [POS_W-1:0] s1_ty_r;
  logic signed [JC_W-1:0]  s1_d_nxt;

  // stage 2: reduced angle
  logic                    s2_valid_r;
  logic [RED_W-1:0]        s2_r_r;
  logic [RED_W-1:0]        s2_r_nxt;
  logic signed [JC_W-1:0]  s2_d_r;
  logic signed [POS_W-1:0] s2_tx_r;
  logic signed [POS_W-1:0] s2_ty_r;
  logic signed [27:0]      d_w;
  logic signed [27:0]      red;

  // stage 3: quotient by 45
  logic                    s3_valid_r;
  logic [QUO_W-1:0]        s3_q_r;
  logic [QUO_W-1:0]        s3_q_nxt;
  logic [RED_W-1:0]        s3_r_r;
  logic signed [JC_W-1:0]  s3_d_r;
  logic signed [POS_W-1:0] s3_tx_r;
  logic signed [POS_W-1:0] s3_ty_r;
  logic [50:0]             recip_prod;

  // stage 4: phase and quadrant fold
  logic                    out_valid_r;
  rot_t                    out_rot_r;
  side_t                   out_side_r;
  logic [RED_W-1:0]        q45;
  logic [REM_W-1:0]        rem;
  logic [PHASE_W-1:0]      phase;
  logic                    neg;
  logic [FRAC_W-1:0]       frac_tab [2**REM_W];

  // rounded fraction table for remainders 0..44
  for (genvar g = 0; g < 2**REM_W; g++) begin : g_frac
    localparam logic [FRAC_W-1:0] FRAC_K = (g < FRAC_CNT) ? FRAC_W'(frac_of(g)) : '0;
    assign frac_tab[g] = FRAC_K;
  end

  // difference of pose angle and tool angle
  assign s1_d_nxt = {in_tcp_angle[ANG_W-1], in_tcp_angle} - {tool_angle[ANG_W-1], tool_angle};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_d_r  <= s1_d_nxt;
    s1_tx_r <= in_tcp_x;
    s1_ty_r <= in_tcp_y;
  end

  // fold into one turn, difference spans under three turns either way
  always_comb begin
    d_w = {s1_d_r[JC_W-1], s1_d_r};
    if (d_w >= FT2) begin
      red = d_w - FT2;
    end else if (d_w >= FT1) begin
      red = d_w - FT1;
    end else if (d_w >= 28'sd0) begin
      red = d_w;
    end else if (d_w >= -FT1) begin
      red = d_w + FT1;
    end else if (d_w >= -FT2) begin
      red = d_w + FT2;
    end else begin
      red = d_w + FT3;
    end
    s2_r_nxt = red[RED_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_r_r  <= s2_r_nxt;
    s2_d_r  <= s1_d_r;
    s2_tx_r <= s1_tx_r;
    s2_ty_r <= s1_ty_r;
  end

  // divide by 45 through the reciprocal
  assign recip_prod = s2_r_r * RECIP_C;
  assign s3_q_nxt   = recip_prod[RECIP_SHIFT +: QUO_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_q_r  <= s3_q_nxt;
    s3_r_r  <= s2_r_r;
    s3_d_r  <= s2_d_r;
    s3_tx_r <= s2_tx_r;
    s3_ty_r <= s2_ty_r;
  end

  // phase = q * 8192 + rounded fraction, then fold the left half plane
  always_comb begin
    q45   = {s3_q_r, 5'b0} + {2'b0, s3_q_r, 3'b0} + {3'b0, s3_q_r, 2'b0}
            + {5'b0, s3_q_r}
            + {RED_W{1'b0}};
    rem   = REM_W'(s3_r_r - q45);
    phase = {s3_q_r, {FRAC_W{1'b0}}} + {{(PHASE_W-FRAC_W){1'b0}}, frac_tab[rem]};
    neg   = phase[PHASE_W-1] ^ phase[PHASE_W-2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_rot_r.x        <= ROT_W'(CORDIC_GAIN_Q30);
    out_rot_r.y        <= '0;
    out_rot_r.z        <= {{(ROT_W-PHASE_W+1){phase[PHASE_W-2]}}, phase[PHASE_W-2:0]};
    out_side_r.tcp_x   <= s3_tx_r;
    out_side_r.tcp_y   <= s3_ty_r;
    out_side_r.joint_c <= s3_d_r;
    out_side_r.neg     <= neg;
  end

  assign out_valid = out_valid_r;
  assign out_rot   = out_rot_r;
  assign out_side  = out_side_r;

  `PXYC_ASSERT_NOW(a_red_range, s2_valid_r, s2_r_r < RED_W'(FULL_TURN), "reduced angle not below one turn")
  `PXYC_ASSERT_NOW(a_rem_range, s3_valid_r, rem < REM_W'(FRAC_CNT), "divide by 45 left a remainder of 45 or more")
  `PXYC_ASSERT_NEXT(a_out_follow, s3_valid_r, out_valid, "phase stage dropped an item")

endmodule

/* rtl/pxyc_cordic_cell.sv */
// one cordic rotation cell: rotates the vector to drive the residual phase toward zero and passes it on
module pxyc_cordic_cell (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  pxyc_pkg::rot_t                      in_rot,
  input  pxyc_pkg::side_t                     in_side,
  input  logic        [pxyc_pkg::SHIFT_W-1:0] shift,
  input  logic signed [pxyc_pkg::ROT_W-1:0]   atan,
  output logic                                out_valid,
  output pxyc_pkg::rot_t                      out_rot,
  output pxyc_pkg::side_t                     out_side
);
  import pxyc_pkg::*;

  logic                    valid_r;
  rot_t                    rot_r;
  rot_t                    rot_nxt;
  side_t                   side_r;
  logic signed [ROT_W-1:0] xs;
  logic signed [ROT_W-1:0] ys;

  // micro-rotation, direction from the sign of the residual phase
  always_comb begin
    xs = $signed(in_rot.x) >>> shift;
    ys = $signed(in_rot.y) >>> shift;
    if (!in_rot.z[ROT_W-1]) begin
      rot_nxt.x = in_rot.x - ys;
      rot_nxt.y = in_rot.y + xs;
      rot_nxt.z = in_rot.z - atan;
    end else begin
      rot_nxt.x = in_rot.x + ys;
      rot_nxt.y = in_rot.y - xs;
      rot_nxt.z = in_rot.z + atan;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    rot_r  <= rot_nxt;
    side_r <= in_side;
  end

  assign out_valid = valid_r;
  assign out_rot   = rot_r;
  assign out_side  = side_r;

endmodule

/* rtl/pxyc_joint_calc.sv */
// tool offset transform, rounding, saturation and limit flag
`include "planar_xyc_inverse_kinematics_top_macros.svh"

module pxyc_joint_calc (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  pxyc_pkg::rot_t                     in_rot,
  input  pxyc_pkg::side_t                    in_side,
  input  pxyc_pkg::cfg_t                     cfg,
  output logic                               out_valid,
  output logic [pxyc_pkg::POS_W-1:0]         out_joint_x,
  output logic [pxyc_pkg::POS_W-1:0]         out_joint_y,
  output logic [pxyc_pkg::JC_W-1:0]          out_joint_c,
  output logic                               out_status
);
  import pxyc_pkg::*;

  localparam int TRIG_W = 32;
  localparam int A_W    = 33;
  localparam int PROD_W = 65;
  localparam int SUM_W  = 66;
  localparam int RND_W  = SUM_W - 28;
  localparam logic signed [RND_W-1:0] POS_MAX = RND_W'(64'sd2147483647);
  localparam logic signed [RND_W-1:0] POS_MIN = -RND_W'(64'sd2147483648);

  // post stage: undo the half-turn fold, round to q28
  logic                     p_valid_r;
  logic signed [TRIG_W-1:0] p_c_r;
  logic signed [TRIG_W-1:0] p_s_r;
  logic signed [A_W-1:0]    p_a_r;
  side_t                    p_side_r;
  logic signed [ROT_W-1:0]  xn;
  logic signed [ROT_W-1:0]  yn;
  logic signed [ROT_W-1:0]  xr;
  logic signed [ROT_W-1:0]  yr;
  logic signed [A_W-1:0]    a_nxt;

  // product stage
  logic                     m_valid_r;
  logic signed [PROD_W-1:0] m_cx_r;
  logic signed [PROD_W-1:0] m_sa_r;
  logic signed [PROD_W-1:0] m_sx_r;
  logic signed [PROD_W-1:0] m_ca_r;
  side_t                    m_side_r;

  // sum stage
  logic                     s_valid_r;
  logic signed [SUM_W-1:0]  s_jx_r;
  logic signed [SUM_W-1:0]  s_jy_r;
  logic signed [SUM_W-1:0]  s_jx_nxt;
  logic signed [SUM_W-1:0]  s_jy_nxt;
  logic signed [SUM_W-1:0]  tx_q28;
  logic signed [SUM_W-1:0]  ty_q28;
  logic signed [JC_W-1:0]   s_jc_r;

  // output stage
  logic                     out_valid_r;
  logic [POS_W-1:0]         jx_r;
  logic [POS_W-1:0]         jy_r;
  logic [JC_W-1:0]          jc_r;
  logic                     status_r;
  logic signed [SUM_W-1:0]  rx;
  logic signed [SUM_W-1:0]  ry;
  logic signed [RND_W-1:0]  jx_full;
  logic signed [RND_W-1:0]  jy_full;
  logic [POS_W-1:0]         jx_sat;
  logic [POS_W-1:0]         jy_sat;

  // sign fold and q30 to q28 rounding
  always_comb begin
    xn    = in_side.neg ? -$signed(in_rot.x) : $signed(in_rot.x);
    yn    = in_side.neg ? -$signed(in_rot.y) : $signed(in_rot.y);
    xr    = xn + ROT_W'(2);
    yr    = yn + ROT_W'(2);
    a_nxt = $signed({{(A_W-ARM_W){1'b0}}, cfg.arm_length})
            + A_W'($signed(cfg.tool_offset_y));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else begin
      p_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    p_c_r    <= xr[TRIG_W+1:2];
    p_s_r    <= yr[TRIG_W+1:2];
    p_a_r    <= a_nxt;
    p_side_r <= in_side;
  end

  // four products, each registered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
    end else begin
      m_valid_r <= p_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    m_cx_r   <= p_c_r * $signed(cfg.tool_offset_x);
    m_sa_r   <= p_s_r * p_a_r;
    m_sx_r   <= p_s_r * $signed(cfg.tool_offset_x);
    m_ca_r   <= p_c_r * p_a_r;
    m_side_r <= p_side_r;
  end

  // exact q28 joint sums
  always_comb begin
    tx_q28   = SUM_W'($signed(m_side_r.tcp_x)) <<< 28;
    ty_q28   = SUM_W'($signed(m_side_r.tcp_y)) <<< 28;
    s_jx_nxt = tx_q28 - SUM_W'(m_cx_r) + SUM_W'(m_sa_r);
    s_jy_nxt = ty_q28 - SUM_W'(m_sx_r) - SUM_W'(m_ca_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else begin
      s_valid_r <= m_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s_jx_r <= s_jx_nxt;
    s_jy_r <= s_jy_nxt;
    s_jc_r <= m_side_r.joint_c;
  end

  // round to 1/1024 mm and saturate; limit uses the unsaturated y
  always_comb begin
    rx      = s_jx_r + SUM_W'(64'sd134217728);
    ry      = s_jy_r + SUM_W'(64'sd134217728);
    jx_full = rx[SUM_W-1:28];
    jy_full = ry[SUM_W-1:28];
    if (jx_full > POS_MAX) begin
      jx_sat = POS_MAX[POS_W-1:0];
    end else if (jx_full < POS_MIN) begin
      jx_sat = POS_MIN[POS_W-1:0];
    end else begin
      jx_sat = jx_full[POS_W-1:0];
    end
    if (jy_full > POS_MAX) begin
      jy_sat = POS_MAX[POS_W-1:0];
    end else if (jy_full < POS_MIN) begin
      jy_sat = POS_MIN[POS_W-1:0];
    end else begin
      jy_sat = jy_full[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    jx_r     <= jx_sat;
    jy_r     <= jy_sat;
    jc_r     <= s_jc_r;
    status_r <= jy_full > RND_W'($signed(cfg.y_limit));
  end

  assign out_valid   = out_valid_r;
  assign out_joint_x = jx_r;
  assign out_joint_y = jy_r;
  assign out_joint_c = jc_r;
  assign out_status  = status_r;

  `PXYC_ASSERT_NOW(a_status_unsat, out_valid_r && $stable(cfg.y_limit) && (jy_r != POS_MAX[POS_W-1:0]) && (jy_r != POS_MIN[POS_W-1:0]), status_r == ($signed(jy_r) > $signed(cfg.y_limit)), "limit flag disagrees with joint y")
  `PXYC_ASSERT_NEXT(a_sum_to_out, s_valid_r, out_valid_r, "output stage dropped an item")

endmodule

/* rtl/planar_xyc_inverse_kinematics_top.sv */
// Planar XY gantry with rotary C axis: inverse kinematics with tool offset.
// An item is one tool-centre pose (in_tcp_x, in_tcp_y, in_tcp_angle), taken
// at a rising edge with start high and busy low. busy stays low: the block
// takes a new pose in every cycle, so throughput is one item per clock.
// Each item gives one result (out_joint_x, out_joint_y, out_joint_c,
// out_status), shown for exactly one cycle with out_valid high.
// An item passes through angle reduction and phase conversion (difference,
// fold, divide by 45, phase), then the chain of cordic rotation cells, and
// then sign fold, products, sums and rounding, each step registered.
// The receiver cannot hold results off; none is needed since nothing stalls.
// Tool offsets, arm length, tool angle and y limit sit in an apb register
// bank (byte address 4 * index); write them only while no item is in flight.
// Synchronous active-low reset empties the pipeline and loads the register
// defaults: arm 650 mm, offsets and tool angle zero, y limit 700 mm.
module planar_xyc_inverse_kinematics_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [31:0]                   in_tcp_x,
  input  logic [31:0]                   in_tcp_y,
  input  logic [25:0]                   in_tcp_angle,
  output logic                          out_valid,
  output logic [31:0]                   out_joint_x,
  output logic [31:0]                   out_joint_y,
  output logic [26:0]                   out_joint_c,
  output logic                          out_status,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pxyc_pkg::PADDR_W-1:0]  paddr,
  input  logic [pxyc_pkg::PDATA_W-1:0]  pwdata,
  output logic [pxyc_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import pxyc_pkg::*;

  cfg_t  cfg;
  logic  in_take;
  logic  vld_chain  [CORDIC_STAGES+1];
  rot_t  rot_chain  [CORDIC_STAGES+1];
  side_t side_chain [CORDIC_STAGES+1];

  assign busy    = 1'b0;
  assign in_take = start & ~busy;

  // configuration registers
  pxyc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // angle reduction and phase
  pxyc_angle_reduce u_reduce (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_take),
    .in_tcp_x     ($signed(in_tcp_x)),
    .in_tcp_y     ($signed(in_tcp_y)),
    .in_tcp_angle ($signed(in_tcp_angle)),
    .tool_angle   (cfg.tool_angle),
    .out_valid    (vld_chain[0]),
    .out_rot      (rot_chain[0]),
    .out_side     (side_chain[0])
  );

  // chain of cordic cells, one rotation each
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    localparam logic signed [ROT_W-1:0] ATAN_K  = ROT_W'(atan_turn(g));
    localparam logic [SHIFT_W-1:0]      SHIFT_K = SHIFT_W'(g);

    pxyc_cordic_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (vld_chain[g]),
      .in_rot    (rot_chain[g]),
      .in_side   (side_chain[g]),
      .shift     (SHIFT_K),
      .atan      (ATAN_K),
      .out_valid (vld_chain[g+1]),
      .out_rot   (rot_chain[g+1]),
      .out_side  (side_chain[g+1])
    );
  end

  // joint positions, rounding and limit flag
  pxyc_joint_calc u_joint (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (vld_chain[CORDIC_STAGES]),
    .in_rot      (rot_chain[CORDIC_STAGES]),
    .in_side     (side_chain[CORDIC_STAGES]),
    .cfg         (cfg),
    .out_valid   (out_valid),
    .out_joint_x (out_joint_x),
    .out_joint_y (out_joint_y),
    .out_joint_c (out_joint_c),
    .out_status  (out_status)
  );

endmodule
